// File: rtl/core/wcr_pkg.sv
// Shared types, constants and the binomial table for the windowed combination rank block.
package wcr_pkg;

	localparam int MASK_BITS = 32;
	localparam int RANK_W    = 30;
	localparam int TAB_N     = 32;
	localparam int GROUP_SZ  = 8;
	localparam int GROUPS    = (MASK_BITS + GROUP_SZ - 1) / GROUP_SZ;

	localparam logic       OP_PLAIN   = 1'b0;
	localparam logic       OP_BLOCKED = 1'b1;
	localparam logic [5:0] WIDTH_RST  = 6'd32;
	localparam logic [5:0] WIN_MAX    = 6'd32;

	typedef logic [RANK_W-1:0]                 rank_t;
	typedef rank_t [MASK_BITS-1:0]             term_vec_t;
	typedef rank_t [TAB_N-1:0][TAB_N-1:0]      binom_tab_t;

	// Per-request window settings that every lane sees.
	typedef struct packed {
		logic       op;
		logic [4:0] lo;
		logic [5:0] len;
		logic [4:0] blk_a;
		logic [4:0] blk_b;
	} lane_ctl_t;

	// Pascal's triangle, evaluated at elaboration.
	function automatic binom_tab_t build_binom();
		binom_tab_t t;
		t = '0;
		for (int n = 0; n < TAB_N; n++) begin
			t[n][0] = rank_t'(1);
			for (int k = 1; k <= n; k++) begin
				t[n][k] = t[n-1][k-1] + ((k < n) ? t[n-1][k] : '0);
			end
		end
		return t;
	endfunction

	localparam binom_tab_t BINOM = build_binom();

endpackage

// File: rtl/core/wcr_lane.sv
// One bit lane: window qualification, binomial row, and table lookup of its term.
module wcr_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [4:0]        idx,
	input  logic              mask_bit,
	input  wcr_pkg::lane_ctl_t ctl,
	input  logic [5:0]        k,
	output logic              qual_s1,
	output wcr_pkg::rank_t    term_s2
);
	import wcr_pkg::*;

	logic [6:0]        win_hi;
	logic              in_win;
	logic [4:0]        pos;
	logic              blk_hit;
	logic              qual;
	logic signed [7:0] cp;
	logic signed [7:0] n_val;
	logic signed [7:0] n_s1;
	logic              term_ok;

	always_comb begin
		win_hi  = {2'b00, ctl.lo} + {1'b0, ctl.len};
		in_win  = (idx >= ctl.lo) && ({2'b00, idx} < win_hi);
		pos     = idx - ctl.lo;
		blk_hit = (ctl.op == OP_BLOCKED) && ((pos == ctl.blk_a) || (pos == ctl.blk_b));
		qual    = mask_bit && in_win && !blk_hit;
		// Blocked positions below this one shift it down in the compacted window.
		cp = $signed({3'b000, pos}) - $signed({7'd0, ctl.blk_a < pos})
			- $signed({7'd0, ctl.blk_b < pos});
		if (ctl.op == OP_BLOCKED) begin
			n_val = $signed({2'b00, ctl.len}) - 8'sd3 - cp;
		end else begin
			n_val = $signed({2'b00, ctl.len}) - $signed({3'b000, pos}) - 8'sd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qual_s1 <= qual;
			n_s1    <= n_val;
		end
	end

	// C(n,k) is zero for negative n or k above n; k is never zero here.
	assign term_ok = qual_s1 && !n_s1[7] && ({2'b00, k} <= n_s1[7:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			term_s2 <= term_ok ? BINOM[n_s1[4:0]][k[4:0]] : '0;
		end
	end

	a_clear_lane_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && !qual_s1 |=> term_s2 == '0)
		else $error("lane produced a term without a qualifying bit");

endmodule

// File: rtl/core/wcr_merge.sv
// Two-stage adder tree that combines the lane terms into the rank.
module wcr_merge (
	input  logic               clk,
	input  logic               en,
	input  wcr_pkg::term_vec_t terms,
	output wcr_pkg::rank_t     rank_s4
);
	import wcr_pkg::*;

	rank_t [GROUPS-1:0] part_s3;
	rank_t [GROUPS-1:0] part_d;
	rank_t              total_d;

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			part_d[g] = '0;
			for (int j = 0; j < GROUP_SZ; j++) begin
				if (g * GROUP_SZ + j < MASK_BITS) begin
					part_d[g] = part_d[g] + terms[g * GROUP_SZ + j];
				end
			end
		end
		total_d = '0;
		for (int g = 0; g < GROUPS; g++) begin
			total_d = total_d + part_s3[g];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			part_s3 <= part_d;
			rank_s4 <= total_d;
		end
	end

endmodule

// File: rtl/core/windowed_combination_rank.sv
// Top level: width register, bit lanes, suffix counts, merge tree and the request pipeline.
// Stages: lane setup, table lookup and two adder-tree levels lie between an accepted request
// and its rank.
// Throughput: one request per cycle; the whole four-stage pipeline holds when the
// result is not taken.
// Reset: arst_n clears the stage valids and sets mask_width to 32.
module windowed_combination_rank (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [5:0]           cfg_wdata,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic                 opcode,
	input  logic [31:0]          full_mask,
	input  logic [4:0]           window_low,
	input  logic [5:0]           window_len,
	input  logic [4:0]           blocked_first,
	input  logic [4:0]           blocked_second,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [29:0]          rank
);
	import wcr_pkg::*;

	logic [5:0]           mask_width_q;
	logic [5:0]           width_c;
	logic                 en;
	logic                 v_s1, v_s2, v_s3, v_s4;
	lane_ctl_t            ctl;
	logic [MASK_BITS-1:0] qual_s1;
	logic [5:0]           k_vec [MASK_BITS];
	term_vec_t            term_s2;
	rank_t                rank_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_width_q <= WIDTH_RST;
		end else if (cfg_we) begin
			mask_width_q <= cfg_wdata;
		end
	end

	assign width_c = (mask_width_q > 6'(MASK_BITS)) ? 6'(MASK_BITS) : mask_width_q;

	always_comb begin
		ctl.op    = opcode;
		ctl.lo    = window_low;
		ctl.len   = (window_len > WIN_MAX) ? WIN_MAX : window_len;
		ctl.blk_a = blocked_first;
		ctl.blk_b = blocked_second;
	end

	// The pipeline moves as one; it holds only while a finished rank waits.
	assign en        = !v_s4 || res_ready;
	assign req_ready = en;
	assign res_valid = v_s4;
	assign rank      = rank_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Each lane's k counts the qualifying bits at or above it.
	always_comb begin
		for (int i = 0; i < MASK_BITS; i++) begin
			k_vec[i] = 6'($countones(qual_s1 & ({MASK_BITS{1'b1}} << i)));
		end
	end

	for (genvar i = 0; i < MASK_BITS; i++) begin : g_lane
		wcr_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.idx      (5'(i)),
			.mask_bit (full_mask[i] && (6'(i) < width_c)),
			.ctl      (ctl),
			.k        (k_vec[i]),
			.qual_s1  (qual_s1[i]),
			.term_s2  (term_s2[i])
		);
	end

	wcr_merge u_merge (
		.clk     (clk),
		.en      (en),
		.terms   (term_s2),
		.rank_s4 (rank_s4)
	);

	a_cfg_written: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> mask_width_q == $past(cfg_wdata))
		else $error("mask width register missed a write");

	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && window_len == 6'd0 |=> v_s1 && qual_s1 == '0)
		else $error("empty window qualified a bit");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(qual_s1) && $stable(term_s2) && v_s4)
		else $error("pipeline moved while stalled");

	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s3 |=> v_s4)
		else $error("request lost between merge stages");

endmodule

// File: dv/windowed_combination_rank_test.sv
// Self-checking testbench for the windowed combination rank block with random handshake idling.
module windowed_combination_rank_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wcr_pkg::*;

	typedef struct {
		logic        op;
		logic [31:0] mask;
		logic [4:0]  low;
		logic [5:0]  len;
		logic [4:0]  blk_a;
		logic [4:0]  blk_b;
	} rank_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [5:0]  cfg_wdata = 6'd0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic        opcode = OP_PLAIN;
	logic [31:0] full_mask = 32'd0;
	logic [4:0]  window_low = 5'd0;
	logic [5:0]  window_len = 6'd0;
	logic [4:0]  blocked_first = 5'd0;
	logic [4:0]  blocked_second = 5'd0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [29:0] rank;

	rank_req_t   pending_requests[$];
	logic [29:0] ranks_due[$];
	logic [5:0]  width_model = WIDTH_RST;

	int          req_gap = 0;
	int          res_stall = 0;
	bit          req_calm = 1'b0;
	bit          res_calm = 1'b0;
	int          mismatches = 0;
	int          failures = 0;
	int          ranks_checked = 0;
	int          plain_sent = 0;
	int          blocked_sent = 0;
	int          widths_written = 0;
	rank_req_t   next_req;

	windowed_combination_rank dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.opcode         (opcode),
		.full_mask      (full_mask),
		.window_low     (window_low),
		.window_len     (window_len),
		.blocked_first  (blocked_first),
		.blocked_second (blocked_second),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.rank           (rank)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Binomial coefficient, zero outside 0 <= k <= n.
	function automatic longint unsigned choose(int n, int k);
		longint unsigned acc;
		int i;
		acc = 1;
		if (n < 0 || k < 0 || k > n)
			return 0;
		if (k > n - k)
			k = n - k;
		for (i = 1; i <= k; i++)
			acc = acc * longint'(n - k + i) / longint'(i);
		return acc;
	endfunction

	function automatic logic [29:0] predict_rank(rank_req_t r, logic [5:0] width_reg);
		int w, len, lo, a, bb, pos, cp, seen, bit_idx;
		logic [31:0] kept;
		longint unsigned total;
		w = int'(width_reg);
		if (w > MASK_BITS)
			w = MASK_BITS;
		len = int'(r.len);
		if (len > int'(WIN_MAX))
			len = int'(WIN_MAX);
		lo = int'(r.low);
		a = int'(r.blk_a);
		bb = int'(r.blk_b);
		kept = (w >= 32) ? r.mask : (r.mask & ((32'd1 << w) - 32'd1));
		seen = 0;
		total = 0;
		for (bit_idx = 31; bit_idx >= 0; bit_idx--) begin
			if (!kept[bit_idx])
				continue;
			if (bit_idx < lo || bit_idx >= lo + len)
				continue;
			pos = bit_idx - lo;
			if (r.op == OP_PLAIN) begin
				seen++;
				total += choose(len - pos - 1, seen);
			end else if (pos != a && pos != bb) begin
				// Blocked positions below this one close the gap they leave.
				cp = pos - ((a < pos) ? 1 : 0) - ((bb < pos) ? 1 : 0);
				seen++;
				total += choose((len - 2) - cp - 1, seen);
			end
		end
		return total[29:0];
	endfunction

	task automatic add_request(logic op, logic [31:0] mask, logic [4:0] low, logic [5:0] len,
			logic [4:0] blk_a, logic [4:0] blk_b);
		rank_req_t r;
		r.op = op;
		r.mask = mask;
		r.low = low;
		r.len = len;
		r.blk_a = blk_a;
		r.blk_b = blk_b;
		pending_requests.push_back(r);
	endtask

	task automatic add_random_request();
		logic [31:0] mask;
		int len, kind, span;
		logic [4:0] a, b;
		kind = $urandom_range(0, 9);
		case (kind)
			0: mask = $urandom() & $urandom() & $urandom();
			1: mask = $urandom() | $urandom();
			2: mask = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
			3: mask = 32'd1 << $urandom_range(0, 31);
			default: mask = $urandom();
		endcase
		kind = $urandom_range(0, 9);
		if (kind == 0)
			len = $urandom_range(0, 2);
		else if (kind == 1)
			len = $urandom_range(33, 63);
		else
			len = $urandom_range(1, 32);
		// Most blocked positions land inside the window so they actually remove bits.
		span = (len > 32) ? 31 : ((len > 0) ? len - 1 : 0);
		if ($urandom_range(0, 9) < 7) begin
			a = 5'($urandom_range(0, span));
			b = 5'($urandom_range(0, span));
		end else begin
			a = 5'($urandom_range(0, 31));
			b = 5'($urandom_range(0, 31));
		end
		if ($urandom_range(0, 6) == 0)
			b = a;
		add_request($urandom_range(0, 1) ? OP_BLOCKED : OP_PLAIN, mask,
			5'($urandom_range(0, 31)), len[5:0], a, b);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || req_valid || ranks_due.size() != 0);
	endtask

	task automatic write_width(logic [5:0] w);
		wait_idle();
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		width_model = w;
		widths_written++;
	endtask

	// Request driver: one item per valid, a random gap drawn with each item and spent after its acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			opcode <= OP_PLAIN;
			full_mask <= 32'd0;
			window_low <= 5'd0;
			window_len <= 6'd0;
			blocked_first <= 5'd0;
			blocked_second <= 5'd0;
			req_gap <= 0;
		end else if (!(req_valid && !req_ready)) begin
			if (req_gap != 0) begin
				req_valid <= 1'b0;
				req_gap <= req_gap - 1;
			end else if (pending_requests.size() != 0) begin
				next_req = pending_requests.pop_front();
				opcode <= next_req.op;
				full_mask <= next_req.mask;
				window_low <= next_req.low;
				window_len <= next_req.len;
				blocked_first <= next_req.blk_a;
				blocked_second <= next_req.blk_b;
				req_valid <= 1'b1;
				if ($urandom_range(0, 15) == 0)
					req_calm = !req_calm;
				req_gap <= req_calm ? 0 : $urandom_range(0, 12);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side: after each accepted rank, hold ready low for a random number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			res_stall = 0;
		end else if (res_valid && res_ready) begin
			if ($urandom_range(0, 15) == 0)
				res_calm = !res_calm;
			res_stall = res_calm ? 0 : $urandom_range(0, 12);
			res_ready <= (res_stall == 0);
		end else if (res_stall != 0) begin
			res_ready <= (res_stall == 1);
			res_stall = res_stall - 1;
		end else begin
			res_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				ranks_due.push_back(predict_rank('{opcode, full_mask, window_low, window_len,
					blocked_first, blocked_second}, width_model));
				if (opcode == OP_PLAIN)
					plain_sent++;
				else
					blocked_sent++;
			end
			if (res_valid && res_ready) begin
				if (ranks_due.size() == 0) begin
					failures++;
					if (mismatches < 10)
						$display("%0t: rank %0d arrived with no request outstanding", $realtime,
							rank);
					mismatches++;
				end else begin
					if (rank !== ranks_due[0]) begin
						failures++;
						if (mismatches < 10)
							$display("%0t: rank mismatch, expected %0d, got %0d", $realtime,
								ranks_due[0], rank);
						mismatches++;
					end
					void'(ranks_due.pop_front());
					ranks_checked++;
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [5:0] phase_widths[10];
		int p, n, drain;
		phase_widths = '{6'd0, 6'd1, 6'd63, 6'd31, 6'd33, 6'd8, 6'd32, 6'd0, 6'd0, 6'd0};
		for (p = 7; p < 10; p++)
			phase_widths[p] = 6'($urandom_range(0, 63));

		// Directed requests at the reset width.
		add_request(OP_PLAIN, 32'hFFFF_FFFF, 5'd0, 6'd32, 5'd0, 5'd0);
		add_request(OP_PLAIN, 32'h0000_0000, 5'd0, 6'd32, 5'd0, 5'd0);
		add_request(OP_PLAIN, 32'h8000_0000, 5'd0, 6'd32, 5'd0, 5'd0);
		add_request(OP_PLAIN, 32'h0000_0001, 5'd0, 6'd1, 5'd0, 5'd0);
		add_request(OP_PLAIN, 32'hFFFF_FFFF, 5'd0, 6'd0, 5'd0, 5'd0);
		add_request(OP_PLAIN, 32'hFFFF_FFFF, 5'd0, 6'd63, 5'd0, 5'd0);
		add_request(OP_PLAIN, 32'hFFFF_FFFF, 5'd31, 6'd32, 5'd0, 5'd0);
		add_request(OP_PLAIN, 32'hAAAA_AAAA, 5'd16, 6'd8, 5'd0, 5'd0);
		add_request(OP_PLAIN, 32'hDEAD_BEEF, 5'd7, 6'd10, 5'd0, 5'd0);
		add_request(OP_PLAIN, 32'h8000_0001, 5'd0, 6'd32, 5'd31, 5'd31);
		add_request(OP_PLAIN, 32'h0000_FFFF, 5'd0, 6'd32, 5'd0, 5'd0);
		add_request(OP_BLOCKED, 32'hFFFF_FFFF, 5'd0, 6'd32, 5'd0, 5'd31);
		add_request(OP_BLOCKED, 32'hFFFF_FFFF, 5'd0, 6'd1, 5'd0, 5'd0);
		add_request(OP_BLOCKED, 32'hFFFF_FFFF, 5'd0, 6'd0, 5'd0, 5'd0);
		add_request(OP_BLOCKED, 32'hFFFF_FFFF, 5'd0, 6'd2, 5'd0, 5'd1);
		add_request(OP_BLOCKED, 32'hFFFF_FFFF, 5'd3, 6'd12, 5'd5, 5'd5);
		add_request(OP_BLOCKED, 32'hFFFF_FFFF, 5'd0, 6'd8, 5'd31, 5'd30);
		add_request(OP_BLOCKED, 32'hFFFF_FFFF, 5'd0, 6'd32, 5'd0, 5'd0);
		add_request(OP_BLOCKED, 32'h5555_5555, 5'd4, 6'd63, 5'd3, 5'd17);
		add_request(OP_BLOCKED, 32'hFFFF_FFFF, 5'd31, 6'd32, 5'd0, 5'd1);
		add_request(OP_BLOCKED, 32'hFFFF_0000, 5'd12, 6'd20, 5'd19, 5'd2);
		add_request(OP_BLOCKED, 32'h0F0F_0F0F, 5'd0, 6'd16, 5'd15, 5'd14);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (p = 0; p < 10; p++) begin
			write_width(phase_widths[p]);
			for (n = 0; n < 185; n++)
				add_random_request();
		end

		wait_idle();
		drain = 0;
		while (drain < 12) begin
			@(posedge clk);
			drain++;
		end
		$display("Checked %0d ranks (%0d plain, %0d blocked requests) over %0d width settings.",
			ranks_checked, plain_sent, blocked_sent, widths_written + 1);
		$display("Failures seen: %0d.", failures);
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
